/* hdl/pol_pkg.sv */
// ----------------------------------------------------------------------------
// pol_pkg
// Shared codes, field widths and controller/datapath bundles for the
// positional ordered list.
// ----------------------------------------------------------------------------
package pol_pkg;

  // defaults for the top level parameters
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the channels
  localparam int FUNC_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int ITEM_W   = 32;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INS_POS   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_DEL_POS   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_DISPLAY   = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

  // cell edit codes
  localparam logic [1:0] ED_NONE = 2'd0;
  localparam logic [1:0] ED_INS  = 2'd1;
  localparam logic [1:0] ED_DEL  = 2'd2;
  localparam logic [1:0] ED_ROT  = 2'd3;

  // edit location codes
  localparam logic [1:0] WH_FRONT = 2'd0;
  localparam logic [1:0] WH_BACK  = 2'd1;
  localparam logic [1:0] WH_POS   = 2'd2;

  typedef struct packed {
    logic [1:0]          edit;
    logic [1:0]          where;
    logic                walk_start;
    logic                load_res;
    logic                res_walk;
    logic [STATUS_W-1:0] res_status;
  } pol_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic ins_pos_ok;
    logic del_pos_ok;
    logic walk_last;
  } pol_stat_t;

endpackage

/* hdl/pol_in_if.sv */
// ----------------------------------------------------------------------------
// pol_in_if
// Operation channel: valid/ready handshake with function, value and position.
// ----------------------------------------------------------------------------
interface pol_in_if;
  logic                               valid;
  logic                               ready;
  logic        [pol_pkg::FUNC_W-1:0]  func;
  logic signed [pol_pkg::VALUE_W-1:0] value;
  logic        [pol_pkg::POS_W-1:0]   position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink   (input valid, input func, input value, input position, output ready);
endinterface

/* hdl/pol_out_if.sv */
// ----------------------------------------------------------------------------
// pol_out_if
// Result channel: valid/ready handshake with status, count, item and last.
// ----------------------------------------------------------------------------
interface pol_out_if;
  logic                                valid;
  logic                                ready;
  logic        [pol_pkg::STATUS_W-1:0] status;
  logic        [pol_pkg::COUNT_W-1:0]  count;
  logic signed [pol_pkg::ITEM_W-1:0]   item;
  logic                                last;

  modport source (output valid, output status, output count, output item, output last,
                  input ready);
  modport sink   (input valid, input status, input count, input item, input last,
                  output ready);
endinterface

/* hdl/pol_ctrl.sv */
// ----------------------------------------------------------------------------
// pol_ctrl
// Controller: decodes each operation against the list status, drives the
// datapath commands and owns the result valid flag and the display walk.
// ----------------------------------------------------------------------------
module pol_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pol_pkg::FUNC_W-1:0]   in_func,
  output logic                         out_valid,
  input  logic                         out_ready,
  input  pol_pkg::pol_stat_t           stat,
  output pol_pkg::pol_cmd_t            cmd
);
  import pol_pkg::*;

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_WALK = 1'b1;

  logic [0:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_res   = 1'b1;
          cmd.res_status = ST_OK;
          case (in_func)
            FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
              if (stat.full) begin
                cmd.res_status = ST_FULL;
              end else if (in_func == FN_INS_POS && !stat.ins_pos_ok) begin
                cmd.res_status = ST_INVALID;
              end else begin
                cmd.edit  = ED_INS;
                cmd.where = (in_func == FN_INS_FRONT) ? WH_FRONT :
                            (in_func == FN_INS_BACK)  ? WH_BACK  : WH_POS;
              end
            end
            FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS: begin
              if (stat.empty) begin
                cmd.res_status = ST_EMPTY;
              end else if (in_func == FN_DEL_POS && !stat.del_pos_ok) begin
                cmd.res_status = ST_INVALID;
              end else begin
                cmd.edit  = ED_DEL;
                cmd.where = (in_func == FN_DEL_FRONT) ? WH_FRONT :
                            (in_func == FN_DEL_BACK)  ? WH_BACK  : WH_POS;
              end
            end
            FN_DISPLAY: begin
              if (stat.empty) begin
                cmd.res_status = ST_EMPTY;
              end else begin
                // elements leave one per cycle from the walk state while the result register is free
                cmd.load_res   = 1'b0;
                cmd.walk_start = 1'b1;
                state_nxt      = S_WALK;
              end
            end
            default: begin
              cmd.res_status = ST_INVALID;
            end
          endcase
        end
      end
      S_WALK: begin
        if (out_free) begin
          cmd.load_res   = 1'b1;
          cmd.res_walk   = 1'b1;
          cmd.res_status = ST_OK;
          cmd.edit       = ED_ROT;
          if (stat.walk_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_res) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/pol_dp.sv */
// ----------------------------------------------------------------------------
// pol_dp
// Datapath: row of shifting element cells, element count, walk counter and
// the registered result payload.
// ----------------------------------------------------------------------------
module pol_dp #(
  parameter int CAPACITY   = pol_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pol_pkg::pol_cmd_t                   cmd,
  input  logic signed [pol_pkg::VALUE_W-1:0]  in_value,
  input  logic        [pol_pkg::POS_W-1:0]    in_position,
  output pol_pkg::pol_stat_t                  stat,
  output logic        [pol_pkg::STATUS_W-1:0] out_status,
  output logic        [pol_pkg::COUNT_W-1:0]  out_count,
  output logic signed [pol_pkg::ITEM_W-1:0]   out_item,
  output logic                                out_last
);
  import pol_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int XW   = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [DATA_WIDTH-1:0] cells_r   [CAPACITY];
  logic [DATA_WIDTH-1:0] cells_nxt [CAPACITY];
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         walk_r, walk_nxt;
  logic [CW-1:0]         walk_inc;
  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         idx_c;
  logic [CMPW-1:0]       pos_e, cnt_e;
  logic [XW-1:0]         val_x, cell_x;
  logic [DATA_WIDTH-1:0] val_d;

  logic [STATUS_W-1:0]   res_status_r;
  logic [COUNT_W-1:0]    res_count_r;
  logic [ITEM_W-1:0]     res_item_r;
  logic                  res_last_r;

  assign pos_e    = CMPW'(in_position);
  assign cnt_e    = CMPW'(count_r);
  assign cnt_m1   = count_r - CW'(1);
  assign walk_inc = walk_r + CW'(1);

  assign stat.full       = (count_r >= CAP_C);
  assign stat.empty      = (count_r == '0);
  assign stat.ins_pos_ok = (pos_e != '0) && (pos_e <= cnt_e + CMPW'(1));
  assign stat.del_pos_ok = (pos_e != '0) && (pos_e <= cnt_e);
  assign stat.walk_last  = (walk_inc == count_r);

  // stored width keeps the low bits, sign extension both ways
  assign val_x  = XW'(signed'(in_value));
  assign val_d  = val_x[DATA_WIDTH-1:0];
  assign cell_x = XW'(signed'(cells_r[0]));

  always_comb begin
    case (cmd.where)
      WH_FRONT: idx_c = '0;
      WH_BACK:  idx_c = (cmd.edit == ED_INS) ? count_r : cnt_m1;
      WH_POS:   idx_c = CW'(pos_e - CMPW'(1));
      default:  idx_c = '0;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] I_C = CW'(i);
    logic [DATA_WIDTH-1:0] left_d, right_d;

    if (i == 0) begin : g_first
      assign left_d = cells_r[i];
    end else begin : g_left
      assign left_d = cells_r[i-1];
    end
    if (i == CAPACITY - 1) begin : g_final
      assign right_d = cells_r[i];
    end else begin : g_right
      assign right_d = cells_r[i+1];
    end

    always_comb begin
      cells_nxt[i] = cells_r[i];
      case (cmd.edit)
        ED_INS: begin
          if (I_C == idx_c) begin
            cells_nxt[i] = val_d;
          end else if (I_C > idx_c) begin
            cells_nxt[i] = left_d;
          end
        end
        ED_DEL: begin
          if (I_C >= idx_c) begin
            cells_nxt[i] = right_d;
          end
        end
        ED_ROT: begin
          // display walk rotates the held elements past cell zero
          if (I_C == cnt_m1) begin
            cells_nxt[i] = cells_r[0];
          end else if (I_C < cnt_m1) begin
            cells_nxt[i] = right_d;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cmd.edit)
      ED_INS:  count_nxt = count_r + CW'(1);
      ED_DEL:  count_nxt = cnt_m1;
      default: count_nxt = count_r;
    endcase
  end

  always_comb begin
    if (cmd.walk_start) begin
      walk_nxt = '0;
    end else if (cmd.res_walk) begin
      walk_nxt = walk_inc;
    end else begin
      walk_nxt = walk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      walk_r  <= '0;
    end else begin
      count_r <= count_nxt;
      walk_r  <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    if (cmd.load_res) begin
      res_status_r <= cmd.res_status;
      res_count_r  <= COUNT_W'(count_nxt);
      res_item_r   <= cmd.res_walk ? cell_x[ITEM_W-1:0] : '0;
      res_last_r   <= cmd.res_walk ? stat.walk_last : 1'b1;
    end
  end

  assign out_status = res_status_r;
  assign out_count  = res_count_r;
  assign out_item   = signed'(res_item_r);
  assign out_last   = res_last_r;

endmodule

/* hdl/positional_ordered_list.sv */
// ----------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list of signed values with positional insert and delete
// and an in-order display walk.
// ----------------------------------------------------------------------------
// Usage: operations arrive on in_ch (func, value, position) and results
// leave on out_ch (status, count, item, last), both valid/ready channels.
// Insert and delete edit the cell row in the cycle the transaction is
// accepted; their single result is valid on the next cycle. With the
// receiver taking every result, a new insert or delete is taken each cycle.
// Display of a non-empty list first starts the walk, then gives one
// element per cycle as the cell row rotates past cell zero; the last
// element carries last = 1. An empty display, a bad code or a
// rejected edit gives one result with last = 1.
// The result register frees as it is taken, so the next transaction is
// accepted in the same cycle the previous result leaves. When out_ch
// stalls, the result holds, the walk pauses and in_ch ready stays low.
// Reset empties the list (count zero); cell contents are not cleared and
// are never read beyond the count.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
  parameter int CAPACITY   = pol_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = pol_pkg::DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pol_in_if.sink    in_ch,
  pol_out_if.source out_ch
);
  import pol_pkg::*;

  pol_cmd_t  cmd;
  pol_stat_t stat;

  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_func   (in_ch.func),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pol_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_value    (in_ch.value),
    .in_position (in_ch.position),
    .stat        (stat),
    .out_status  (out_ch.status),
    .out_count   (out_ch.count),
    .out_item    (out_ch.item),
    .out_last    (out_ch.last)
  );

endmodule
